>>> rtl/ppd_pkg.sv
package ppd_pkg;

  // Field widths fixed by the interface
  localparam int SIZE_W         = 13;
  localparam int BYTE_W         = 8;
  localparam int DELTA_W        = 9;
  localparam int BTN_W          = 3;
  localparam int CFG_IDX_W      = 1;
  localparam int COORD_BITS_DEF = 12;
  localparam int QUEUE_DEPTH    = 2;

  // Screen size after reset
  localparam logic [SIZE_W-1:0] SCREEN_W_RST = 13'd1024;
  localparam logic [SIZE_W-1:0] SCREEN_H_RST = 13'd768;

  // Flag byte bits
  localparam logic [BYTE_W-1:0] FLAG_OVF_MASK = 8'hC0;
  localparam logic [BYTE_W-1:0] FLAG_SYNC_BIT = 8'h08;
  localparam int                FLAG_XSIGN    = 4;
  localparam int                FLAG_YSIGN    = 5;
  localparam int                BUTTON_L_BIT  = 0;
  localparam int                BUTTON_R_BIT  = 1;
  localparam int                BUTTON_M_BIT  = 2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 1'd0,
    REG_SCREEN_HEIGHT = 1'd1
  } cfg_reg_t;

  // Classified packet passed from front to back
  typedef struct packed {
    logic               ok;
    logic [BTN_W-1:0]   buttons;
    logic [DELTA_W-1:0] dx;
    logic [DELTA_W-1:0] dy;
  } pkt_t;

endpackage

>>> rtl/ppd_front.sv
module ppd_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_aux_source,
  input  logic [ppd_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                         q_full,
  output logic                         q_push,
  output ppd_pkg::pkt_t                q_pkt
);

  typedef enum logic [1:0] {
    PH_FLAG,
    PH_X,
    PH_Y
  } phase_t;

  phase_t                       phase_r, phase_nxt;
  logic [ppd_pkg::BYTE_W-1:0]   flag_r, flag_nxt;
  logic [ppd_pkg::BYTE_W-1:0]   xb_r, xb_nxt;
  logic                         take;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready && in_aux_source;

  // Gather bytes of a packet; push on the third
  always_comb begin
    phase_nxt = phase_r;
    flag_nxt  = flag_r;
    xb_nxt    = xb_r;
    q_push    = 1'b0;
    if (take) begin
      unique case (phase_r)
        PH_FLAG: begin
          flag_nxt  = in_data_byte;
          phase_nxt = PH_X;
        end
        PH_X: begin
          xb_nxt    = in_data_byte;
          phase_nxt = PH_Y;
        end
        PH_Y: begin
          q_push    = 1'b1;
          phase_nxt = PH_FLAG;
        end
        default: phase_nxt = PH_FLAG;
      endcase
    end
  end

  // Classify the completed packet
  always_comb begin
    q_pkt.ok      = ((flag_r & ppd_pkg::FLAG_OVF_MASK) == '0) &&
                    ((flag_r & ppd_pkg::FLAG_SYNC_BIT) != '0);
    q_pkt.buttons = flag_r[ppd_pkg::BTN_W-1:0];
    q_pkt.dx      = {flag_r[ppd_pkg::FLAG_XSIGN], xb_r};
    q_pkt.dy      = {flag_r[ppd_pkg::FLAG_YSIGN], in_data_byte};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_FLAG;
      flag_r  <= '0;
      xb_r    <= '0;
    end else begin
      phase_r <= phase_nxt;
      flag_r  <= flag_nxt;
      xb_r    <= xb_nxt;
    end
  end

endmodule

>>> rtl/ppd_queue.sv
module ppd_queue #(
  parameter int DEPTH = ppd_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ppd_pkg::pkt_t push_pkt,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output ppd_pkg::pkt_t pop_pkt
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ppd_pkg::pkt_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_pkt   = mem_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_pkt;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/ppd_back.sv
module ppd_back #(
  parameter int COORD_BITS = ppd_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ppd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ppd_pkg::SIZE_W-1:0]      cfg_data,
  input  logic                            q_not_empty,
  input  ppd_pkg::pkt_t                   q_pkt,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_packet_ok,
  output logic [COORD_BITS-1:0]           out_pos_x,
  output logic [COORD_BITS-1:0]           out_pos_y,
  output logic                            out_button_left,
  output logic                            out_button_right,
  output logic                            out_button_middle,
  output logic signed [ppd_pkg::BYTE_W-1:0] out_delta_x,
  output logic signed [ppd_pkg::BYTE_W-1:0] out_delta_y
);

  localparam int SIZE_W  = ppd_pkg::SIZE_W;
  localparam int DELTA_W = ppd_pkg::DELTA_W;
  localparam int CALC_W  = ((COORD_BITS > SIZE_W) ? COORD_BITS : SIZE_W) + 2;

  // Largest coordinate for a screen size
  function automatic logic [COORD_BITS-1:0] axis_limit(input logic [SIZE_W-1:0] size);
    logic [CALC_W-1:0] lim;
    logic [CALC_W-1:0] cmax;
    cmax = CALC_W'((1 << COORD_BITS) - 1);
    if (size == '0) lim = '0;
    else            lim = CALC_W'(size) - CALC_W'(1);
    if (lim > cmax) lim = cmax;
    return lim[COORD_BITS-1:0];
  endfunction

  // Centre of an axis, held within its limit
  function automatic logic [COORD_BITS-1:0] axis_centre(input logic [SIZE_W-1:0] size);
    logic [CALC_W-1:0] c;
    logic [CALC_W-1:0] lim;
    c   = CALC_W'(size >> 1);
    lim = CALC_W'(axis_limit(size));
    if (c > lim) c = lim;
    return c[COORD_BITS-1:0];
  endfunction

  // Clamp a signed coordinate into zero..limit
  function automatic logic [COORD_BITS-1:0] clamp_axis(input logic signed [CALC_W-1:0] v,
                                                       input logic [COORD_BITS-1:0] lim);
    logic signed [CALC_W-1:0] lim_s;
    lim_s = $signed(CALC_W'(lim));
    if (v < 0)     return '0;
    if (v > lim_s) return lim;
    return v[COORD_BITS-1:0];
  endfunction

  logic [COORD_BITS-1:0]        lim_x_r, lim_y_r, ctr_x_r, ctr_y_r;
  logic [COORD_BITS-1:0]        cur_x_r, cur_y_r;
  logic [ppd_pkg::BTN_W-1:0]    buttons_r;
  logic [ppd_pkg::BYTE_W-1:0]   held_dx_r, held_dy_r;
  logic                         out_valid_r;
  logic                         ok_r;
  logic [COORD_BITS-1:0]        pos_x_r, pos_y_r;
  logic [ppd_pkg::BTN_W-1:0]    btn_out_r;
  logic [ppd_pkg::BYTE_W-1:0]   dx_out_r, dy_out_r;

  logic signed [CALC_W-1:0]     sum_x, sum_y;
  logic [COORD_BITS-1:0]        cur_x_nxt, cur_y_nxt;
  logic [ppd_pkg::BTN_W-1:0]    buttons_nxt;
  logic [ppd_pkg::BYTE_W-1:0]   held_dx_nxt, held_dy_nxt;
  logic [COORD_BITS-1:0]        new_lim, new_ctr;

  assign q_pop = q_not_empty && (!out_valid_r || out_ready);

  // Move the pointer: add X, subtract Y
  always_comb begin
    sum_x = $signed(CALC_W'(cur_x_r)) +
            $signed({{(CALC_W-DELTA_W){q_pkt.dx[DELTA_W-1]}}, q_pkt.dx});
    sum_y = $signed(CALC_W'(cur_y_r)) -
            $signed({{(CALC_W-DELTA_W){q_pkt.dy[DELTA_W-1]}}, q_pkt.dy});
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    buttons_nxt = buttons_r;
    held_dx_nxt = held_dx_r;
    held_dy_nxt = held_dy_r;
    if (q_pkt.ok) begin
      cur_x_nxt   = clamp_axis(sum_x, lim_x_r);
      cur_y_nxt   = clamp_axis(sum_y, lim_y_r);
      buttons_nxt = q_pkt.buttons;
      held_dx_nxt = q_pkt.dx[ppd_pkg::BYTE_W-1:0];
      held_dy_nxt = q_pkt.dy[ppd_pkg::BYTE_W-1:0];
    end
  end

  assign new_lim = axis_limit(cfg_data);
  assign new_ctr = axis_centre(cfg_data);

  // Pointer state, screen limits and recentre on size writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_x_r   <= axis_limit(ppd_pkg::SCREEN_W_RST);
      lim_y_r   <= axis_limit(ppd_pkg::SCREEN_H_RST);
      ctr_x_r   <= axis_centre(ppd_pkg::SCREEN_W_RST);
      ctr_y_r   <= axis_centre(ppd_pkg::SCREEN_H_RST);
      cur_x_r   <= axis_centre(ppd_pkg::SCREEN_W_RST);
      cur_y_r   <= axis_centre(ppd_pkg::SCREEN_H_RST);
      buttons_r <= '0;
      held_dx_r <= '0;
      held_dy_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppd_pkg::REG_SCREEN_WIDTH: begin
          lim_x_r <= new_lim;
          ctr_x_r <= new_ctr;
          cur_x_r <= new_ctr;
          cur_y_r <= ctr_y_r;
        end
        ppd_pkg::REG_SCREEN_HEIGHT: begin
          lim_y_r <= new_lim;
          ctr_y_r <= new_ctr;
          cur_x_r <= ctr_x_r;
          cur_y_r <= new_ctr;
        end
        default: ;
      endcase
    end else if (q_pop) begin
      cur_x_r   <= cur_x_nxt;
      cur_y_r   <= cur_y_nxt;
      buttons_r <= buttons_nxt;
      held_dx_r <= held_dx_nxt;
      held_dy_r <= held_dy_nxt;
    end
  end

  // Output register: load on pop, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ok_r      <= q_pkt.ok;
      pos_x_r   <= cur_x_nxt;
      pos_y_r   <= cur_y_nxt;
      btn_out_r <= buttons_nxt;
      dx_out_r  <= held_dx_nxt;
      dy_out_r  <= held_dy_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_packet_ok     = ok_r;
  assign out_pos_x         = pos_x_r;
  assign out_pos_y         = pos_y_r;
  assign out_button_left   = btn_out_r[ppd_pkg::BUTTON_L_BIT];
  assign out_button_right  = btn_out_r[ppd_pkg::BUTTON_R_BIT];
  assign out_button_middle = btn_out_r[ppd_pkg::BUTTON_M_BIT];
  assign out_delta_x       = $signed(dx_out_r);
  assign out_delta_y       = $signed(dy_out_r);

endmodule

>>> rtl/pointer_packet_decoder.sv
// Path: a packet's third byte is written into the queue at the clock edge that takes it; the
// packet then pops into the output register, which raises out_valid, when that register is
// empty or its result is being taken.
// Throughput: one byte per cycle, sustained while the result side keeps taking results.
// Reset (rst_n low, synchronous): packet gathering restarts, queue and output empty,
// screen 1024 x 768, pointer centred, buttons released, held deltas zero.
module pointer_packet_decoder #(
  parameter int COORD_BITS = ppd_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_aux_source,
  input  logic [ppd_pkg::BYTE_W-1:0]        in_data_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_packet_ok,
  output logic [COORD_BITS-1:0]             out_pos_x,
  output logic [COORD_BITS-1:0]             out_pos_y,
  output logic                              out_button_left,
  output logic                              out_button_right,
  output logic                              out_button_middle,
  output logic signed [ppd_pkg::BYTE_W-1:0] out_delta_x,
  output logic signed [ppd_pkg::BYTE_W-1:0] out_delta_y,
  input  logic                              cfg_we,
  input  logic [ppd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ppd_pkg::SIZE_W-1:0]        cfg_data
);

  logic          q_push, q_full, q_pop, q_not_empty;
  ppd_pkg::pkt_t push_pkt, pop_pkt;

  // Gather and classify packets
  ppd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_aux_source(in_aux_source),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_pkt        (push_pkt)
  );

  // Hold classified packets between front and back
  ppd_queue #(
    .DEPTH(ppd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_pkt (push_pkt),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .pop_pkt  (pop_pkt)
  );

  // Update the pointer and present results
  ppd_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .q_not_empty      (q_not_empty),
    .q_pkt            (pop_pkt),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_packet_ok    (out_packet_ok),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_button_left  (out_button_left),
    .out_button_right (out_button_right),
    .out_button_middle(out_button_middle),
    .out_delta_x      (out_delta_x),
    .out_delta_y      (out_delta_y)
  );

endmodule
